### src/cst_pkg.sv
// Shared types, character codes and the per-byte decode function of the CSV tokenizer.
package cst_pkg;

   // Command codes of the input channel.
   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Characters that steer the tokenizer.
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   // Line and quoting state kept between items.
   typedef struct packed {
      logic quoted;
      logic quote_pending;
      logic cr_pending;
      logic line_started;
      logic line_nonempty;
      logic on_header_line;
   } cst_state_type;

   // One result item as it sits in the response queue.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       field_end;
      logic       record_end;
      logic       header_row;
      logic       last;
   } cst_result_type;

   // Outcome of feeding one line byte through the quote logic.
   typedef struct packed {
      logic       emit;
      logic [7:0] res_byte;
      logic       field_end;
      logic       quoted;
      logic       quote_pending;
   } cst_take_type;

   // Quote handling for one byte that belongs to the line.
   function automatic cst_take_type take_byte(input logic [7:0] c, input logic quoted,
                                              input logic quote_pending);
      cst_take_type t;
      logic         done;
      t.emit          = 1'b0;
      t.res_byte      = 8'h00;
      t.field_end     = 1'b0;
      t.quoted        = quoted;
      t.quote_pending = quote_pending;
      done            = 1'b0;
      // A quote after a pending quote is an escaped quote; anything else closes quoting.
      if (t.quote_pending) begin
         t.quote_pending = 1'b0;
         if (c == CHAR_QUOTE) begin
            t.emit     = 1'b1;
            t.res_byte = CHAR_QUOTE;
            done       = 1'b1;
         end else begin
            t.quoted = 1'b0;
         end
      end
      if (!done) begin
         if (c == CHAR_QUOTE) begin
            if (t.quoted) begin
               t.quote_pending = 1'b1;
            end else begin
               t.quoted = 1'b1;
            end
         end else if (c == CHAR_COMMA && !t.quoted) begin
            t.emit      = 1'b1;
            t.field_end = 1'b1;
         end else begin
            t.emit     = 1'b1;
            t.res_byte = c;
         end
      end
      return t;
   endfunction

endpackage

### src/cst_req_if.sv
// Input channel of the CSV tokenizer: command and raw content byte.
interface cst_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] in_byte;

   modport source (output valid, output cmd, output in_byte, input ready);
   modport sink   (input valid, input cmd, input in_byte, output ready);
endinterface

### src/cst_rsp_if.sv
// Result channel of the CSV tokenizer: field bytes and field-end marks.
interface cst_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       field_end;
   logic       record_end;
   logic       header_row;
   logic       last;

   modport source (output valid, output out_byte, output field_end, output record_end,
                   output header_row, output last, input ready);
   modport sink   (input valid, input out_byte, input field_end, input record_end,
                   input header_row, input last, output ready);
endinterface

### src/cst_parse.sv
// Per-item decode: next tokenizer state and the zero to two results one item causes.
module cst_parse (
   input  cst_pkg::cst_state_type  state_ff,
   input  logic                    cmd,
   input  logic [7:0]              in_byte,
   output cst_pkg::cst_state_type  state_in,
   output logic [1:0]              res_count,
   output cst_pkg::cst_result_type res0,
   output cst_pkg::cst_result_type res1
);
   import cst_pkg::*;

   cst_take_type   take_cr;
   cst_take_type   take_c;
   logic           cr_quoted;
   logic           cr_pending_q;
   cst_result_type res_a;
   cst_result_type res_b;
   logic           emit_a;
   logic           emit_b;

   // A held CR is replayed as a data byte ahead of the new byte.
   assign take_cr      = take_byte(CHAR_CR, state_ff.quoted, state_ff.quote_pending);
   assign cr_quoted    = state_ff.cr_pending ? take_cr.quoted : state_ff.quoted;
   assign cr_pending_q = state_ff.cr_pending ? take_cr.quote_pending
                                             : state_ff.quote_pending;
   assign take_c       = take_byte(in_byte, cr_quoted, cr_pending_q);

   // Decide state and the two candidate results.
   always_comb begin
      state_in = state_ff;
      emit_a   = 1'b0;
      emit_b   = 1'b0;
      res_a    = '{out_byte: 8'h00, field_end: 1'b1, record_end: 1'b1,
                   header_row: state_ff.on_header_line, last: 1'b0};
      res_b    = res_a;
      if (cmd == CMD_END) begin
         // End of content closes an open line and restores the reset state.
         emit_a                  = (state_ff.on_header_line && state_ff.line_started) ||
                                   state_ff.line_nonempty;
         state_in                = '0;
         state_in.on_header_line = 1'b1;
      end else if (in_byte == CHAR_LF) begin
         // Newline ends the line; the header line is reported even when empty.
         emit_a                  = state_ff.on_header_line || state_ff.line_nonempty;
         state_in                = '0;
         state_in.on_header_line = 1'b0;
      end else begin
         state_in.line_started = 1'b1;
         if (state_ff.cr_pending) begin
            emit_a                 = take_cr.emit;
            res_a.out_byte         = take_cr.res_byte;
            res_a.field_end        = take_cr.field_end;
            res_a.record_end       = 1'b0;
            state_in.line_nonempty = 1'b1;
            state_in.quoted        = take_cr.quoted;
            state_in.quote_pending = take_cr.quote_pending;
         end
         if (in_byte == CHAR_CR) begin
            state_in.cr_pending = 1'b1;
         end else begin
            state_in.cr_pending    = 1'b0;
            emit_b                 = take_c.emit;
            res_b.out_byte         = take_c.res_byte;
            res_b.field_end        = take_c.field_end;
            res_b.record_end       = 1'b0;
            state_in.line_nonempty = 1'b1;
            state_in.quoted        = take_c.quoted;
            state_in.quote_pending = take_c.quote_pending;
         end
      end
   end

   // Pack the emitted results to the front and mark the final one.
   always_comb begin
      res0      = res_a;
      res1      = res_b;
      res_count = {1'b0, emit_a} + {1'b0, emit_b};
      if (emit_a && emit_b) begin
         res1.last = 1'b1;
      end else if (emit_b) begin
         res0      = res_b;
         res0.last = 1'b1;
      end else begin
         res0.last = 1'b1;
      end
   end

endmodule

### src/cst_rsp_fifo.sv
// Result queue that takes up to two results per cycle and hands out one per cycle while the receiver is ready.
module cst_rsp_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              push_count,
   input  cst_pkg::cst_result_type push0,
   input  cst_pkg::cst_result_type push1,
   output logic                    room,
   cst_rsp_if.source               rsp
);
   import cst_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] LIMIT = CW'(DEPTH - 2);
   localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);

   cst_result_type mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff;
   logic [AW-1:0]  wr_ptr_in;
   logic [AW-1:0]  wr_next;
   logic [AW-1:0]  rd_ptr_ff;
   logic [AW-1:0]  rd_ptr_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   logic           pop;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == LAST) ? '0 : p + AW'(1);
   endfunction

   assign room   = (count_ff <= LIMIT);
   assign pop    = rsp.valid && rsp.ready;
   assign wr_next = ptr_inc(wr_ptr_ff);

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_count == 2'd1) begin
         wr_ptr_in = wr_next;
      end else if (push_count == 2'd2) begin
         wr_ptr_in = ptr_inc(wr_next);
      end
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push_count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage for queued results.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_next] <= push1;
      end
   end

   // The head entry drives the result channel.
   assign rsp.valid      = (count_ff != '0);
   assign rsp.out_byte   = mem_ff[rd_ptr_ff].out_byte;
   assign rsp.field_end  = mem_ff[rd_ptr_ff].field_end;
   assign rsp.record_end = mem_ff[rd_ptr_ff].record_end;
   assign rsp.header_row = mem_ff[rd_ptr_ff].header_row;
   assign rsp.last       = mem_ff[rd_ptr_ff].last;

endmodule

### src/csv_stream_tokenizer_core.sv
// Top level of the streaming CSV tokenizer.
//
// The req channel carries one item per cycle while req.ready is high: a content
// byte (cmd = data) or an end-of-content mark (cmd = end, byte ignored). The
// rsp channel returns field bytes and field-end marks, with record_end on the
// last field of a line, header_row on every result of the first line, and last
// on the final result that an input item causes. An item may cause zero, one
// or two results. An item is decoded in the cycle it is accepted; its results
// sit in the result queue from the next cycle on. Throughput is one input item
// per cycle while the queue has room; sustained output is one result per cycle
// if the receiver is ready, set by the single read port of the result queue.
// req.ready is high while the queue has room for two more results, so a
// stalled receiver backs up the input once DEPTH-1 or more results are queued,
// and no result is lost. Synchronous reset empties the queue and returns the
// tokenizer to the start of new content, on the header line.
module csv_stream_tokenizer_core #(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   cst_req_if.sink    req,
   cst_rsp_if.source  rsp
);
   import cst_pkg::*;

   cst_state_type  state_ff;
   cst_state_type  state_in;
   cst_result_type res0;
   cst_result_type res1;
   logic [1:0]     res_count;
   logic [1:0]     push_count;
   logic           room;
   logic           accept;

   assign req.ready  = room;
   assign accept     = req.valid && req.ready;
   assign push_count = accept ? res_count : 2'd0;

   // Decode of the incoming item against the current line state.
   cst_parse u_parse (
      .state_ff  (state_ff),
      .cmd       (req.cmd),
      .in_byte   (req.in_byte),
      .state_in  (state_in),
      .res_count (res_count),
      .res0      (res0),
      .res1      (res1)
   );

   // Line and quoting state advances on each accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{on_header_line: 1'b1, default: 1'b0};
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Queue of results waiting for the receiver.
   cst_rsp_fifo #(
      .DEPTH (DEPTH)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (res0),
      .push1      (res1),
      .room       (room),
      .rsp        (rsp)
   );

endmodule
